// ----- rtl/core/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants for the base32 decoder
// Result record, result kinds, character codes and defaults used by the
// decode stage, the result queue and the top level.
// ----------------------------------------------------------------------------
package b32d_pkg;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// configuration default
	localparam logic [15:0] CAPACITY_RESET = 16'hffff;

	// result queue address width (depth is a power of two, at least 4)
	localparam int unsigned RESULT_QUEUE_AW = 3;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_L  = 8'h4c;
	localparam logic [7:0] CH_UP_O  = 8'h4f;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;
	localparam logic [7:0] LETTER_MASK = 8'h1f;
	localparam logic [7:0] DIGIT_BASE  = 8'd24;  // '2' maps to 26

	// one result record
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_count;
		logic        has_room;
		logic        end_of_run;
	} result_t;

	// up to two results written per decoded character
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ----- rtl/core/b32d_if.sv -----
// ----------------------------------------------------------------------------
// b32d_if: channel interfaces of the base32 decoder
// Character input, result output and capacity configuration channels,
// each a valid/ready request channel.
// ----------------------------------------------------------------------------
interface b32d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_string;

	modport source (output valid, char_code, end_of_string, input ready);
	modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

interface b32d_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_count;
	logic        has_room;
	logic        end_of_run;

	modport source (output valid, kind, data_byte, byte_count, has_room, end_of_run,
		input ready);
	modport sink   (input valid, kind, data_byte, byte_count, has_room, end_of_run,
		output ready);
endinterface

interface b32d_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/b32d_decode.sv -----
// ----------------------------------------------------------------------------
// b32d_decode: character decode and bit buffer
// Maps the registered character to a 5-bit group, updates the bit buffer,
// byte count and discard flag, and forms up to two results.
// ----------------------------------------------------------------------------
module b32d_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [7:0]        char_s1,
	input  logic              last_s1,
	input  logic [15:0]       capacity,
	output b32d_pkg::push_t   push
);

	logic [11:0] bit_buffer_q;
	logic [3:0]  bit_count_q;
	logic [15:0] bytes_out_q;
	logic        discarding_q;

	logic [11:0] nxt_buffer;
	logic [3:0]  nxt_count;
	logic [15:0] nxt_bytes;
	logic        nxt_discard;
	logic [1:0]  num;
	b32d_pkg::result_t r0;
	b32d_pkg::result_t r1;

	function automatic b32d_pkg::result_t mk_result(logic [1:0] kind, logic [7:0] data,
		logic [15:0] count, logic room);
		b32d_pkg::result_t r;
		r.kind       = kind;
		r.data_byte  = data;
		r.byte_count = count;
		r.has_room   = room;
		r.end_of_run = 1'b0;
		return r;
	endfunction

	// next state and results
	always_comb begin
		logic [7:0]  mch;
		logic        is_letter;
		logic        is_digit;
		logic [4:0]  group;
		logic        skip;
		logic        failed;
		logic [11:0] shifted;
		logic [3:0]  cnt5;
		logic [2:0]  amt;
		logic [7:0]  dbyte;
		b32d_pkg::result_t done_r;

		nxt_buffer  = bit_buffer_q;
		nxt_count   = bit_count_q;
		nxt_bytes   = bytes_out_q;
		nxt_discard = discarding_q;
		num         = 2'd0;
		r0          = mk_result(b32d_pkg::KIND_BYTE, 8'd0, 16'd0, 1'b0);
		r1          = r0;
		failed      = 1'b0;
		shifted     = 12'd0;
		cnt5        = 4'd0;
		amt         = 3'd0;
		dbyte       = 8'd0;

		// alphabet mapping, with look-alike digits folded to letters
		case (char_s1)
			b32d_pkg::CH_ZERO:  mch = b32d_pkg::CH_UP_O;
			b32d_pkg::CH_ONE:   mch = b32d_pkg::CH_UP_L;
			b32d_pkg::CH_EIGHT: mch = b32d_pkg::CH_UP_B;
			default:            mch = char_s1;
		endcase
		is_letter = mch inside {[b32d_pkg::CH_UP_A:b32d_pkg::CH_UP_Z],
			[b32d_pkg::CH_LO_A:b32d_pkg::CH_LO_Z]};
		is_digit  = mch inside {[b32d_pkg::CH_TWO:b32d_pkg::CH_SEVEN]};
		group     = is_letter ? 5'((mch & b32d_pkg::LETTER_MASK) - 8'd1)
			: 5'(mch - b32d_pkg::DIGIT_BASE);
		skip      = char_s1 inside {b32d_pkg::CH_SPACE, b32d_pkg::CH_TAB, b32d_pkg::CH_CR,
			b32d_pkg::CH_LF, b32d_pkg::CH_DASH, b32d_pkg::CH_DOT};
		done_r    = mk_result(b32d_pkg::KIND_DONE, 8'd0, 16'd0, 1'b0);

		if (discarding_q) begin
			// swallow the rest of the string
			if (last_s1) begin
				nxt_buffer  = 12'd0;
				nxt_count   = 4'd0;
				nxt_bytes   = 16'd0;
				nxt_discard = 1'b0;
			end
		end else if (char_s1 == b32d_pkg::CH_NUL) begin
			// NUL ends the string now
			r0 = mk_result(b32d_pkg::KIND_DONE, 8'd0, bytes_out_q, bytes_out_q < capacity);
			r0.end_of_run = 1'b1;
			num         = 2'd1;
			nxt_buffer  = 12'd0;
			nxt_count   = 4'd0;
			nxt_bytes   = 16'd0;
			nxt_discard = !last_s1;
		end else begin
			if (bytes_out_q < capacity && !skip) begin
				if (!is_letter && !is_digit) begin
					failed      = 1'b1;
					r0          = mk_result(b32d_pkg::KIND_ERROR, 8'd0, bytes_out_q, 1'b0);
					r0.end_of_run = 1'b1;
					num         = 2'd1;
					nxt_buffer  = 12'd0;
					nxt_count   = 4'd0;
					nxt_bytes   = 16'd0;
					nxt_discard = !last_s1;
				end else begin
					shifted = {bit_buffer_q[6:0], group};
					cnt5    = bit_count_q + 4'd5;
					if (cnt5 >= 4'd8) begin
						// a full byte is ready
						amt        = 3'(cnt5 - 4'd8);
						dbyte      = 8'(shifted >> amt);
						nxt_count  = cnt5 - 4'd8;
						nxt_buffer = shifted & ((12'd1 << nxt_count) - 12'd1);
						nxt_bytes  = bytes_out_q + 16'd1;
						r0         = mk_result(b32d_pkg::KIND_BYTE, dbyte, nxt_bytes, 1'b0);
						num        = 2'd1;
					end else begin
						nxt_count  = cnt5;
						nxt_buffer = shifted;
					end
				end
			end
			// end of string: done result, drop leftover bits
			if (!failed && last_s1) begin
				done_r = mk_result(b32d_pkg::KIND_DONE, 8'd0, nxt_bytes, nxt_bytes < capacity);
				if (num == 2'd0) begin
					r0 = done_r;
				end else begin
					r1 = done_r;
				end
				num         = num + 2'd1;
				nxt_buffer  = 12'd0;
				nxt_count   = 4'd0;
				nxt_bytes   = 16'd0;
				nxt_discard = 1'b0;
			end
			if (!failed) begin
				if (num == 2'd1) begin
					r0.end_of_run = 1'b1;
				end
				if (num == 2'd2) begin
					r1.end_of_run = 1'b1;
				end
			end
		end
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_buffer_q <= 12'd0;
			bit_count_q  <= 4'd0;
			bytes_out_q  <= 16'd0;
			discarding_q <= 1'b0;
		end else if (valid_s1) begin
			bit_buffer_q <= nxt_buffer;
			bit_count_q  <= nxt_count;
			bytes_out_q  <= nxt_bytes;
			discarding_q <= nxt_discard;
		end
	end

	assign push.num = valid_s1 ? num : 2'd0;
	assign push.r0  = r0;
	assign push.r1  = r1;

endmodule

// ----- rtl/core/b32d_result_queue.sv -----
// ----------------------------------------------------------------------------
// b32d_result_queue: result queue
// Takes up to two results per cycle from the decode stage and hands them
// out one at a time on the result channel.
// ----------------------------------------------------------------------------
module b32d_result_queue #(
	parameter int unsigned AW = b32d_pkg::RESULT_QUEUE_AW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b32d_pkg::push_t       push,
	output logic [AW:0]           count,
	b32d_result_if.source         result_out
);

	localparam int unsigned DEPTH = 1 << AW;

	b32d_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          pop;
	b32d_pkg::result_t head;

	assign pop  = result_out.valid && result_out.ready;
	assign head = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(push.num) - (AW+1)'(pop);
		end
	end

	assign count                 = count_q;
	assign result_out.valid      = count_q != '0;
	assign result_out.kind       = head.kind;
	assign result_out.data_byte  = head.data_byte;
	assign result_out.byte_count = head.byte_count;
	assign result_out.has_room   = head.has_room;
	assign result_out.end_of_run = head.end_of_run;

endmodule

// ----- rtl/core/base32_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base32_decoder_unit: streaming base32 decoder
// Decodes one base32 character per cycle while ready into bytes, done, errors.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while char_in.ready is high.
// An accepted character is registered, decoded in the following cycle and
// its results (none, one or two) are written to a result queue of
// 2**QUEUE_AW entries. A result passes through the input register and the
// result queue before it shows on result_out. The result channel delivers
// one result per cycle while result_out.ready is high, so the sustained
// rate is one character per cycle as long as characters average at most
// one result each; char_in.ready drops while the queue could not take two
// more results from both the registered character and a new one. The
// capacity register is written through cfg, which is always ready, and
// must only change while no string is being decoded.
module base32_decoder_unit #(
	parameter int unsigned QUEUE_AW = b32d_pkg::RESULT_QUEUE_AW
) (
	input  logic           clk,
	input  logic           arst_n,
	b32d_char_if.sink      char_in,
	b32d_result_if.source  result_out,
	b32d_cfg_if.sink       cfg
);

	localparam int unsigned DEPTH = 1 << QUEUE_AW;
	localparam logic [QUEUE_AW+1:0] ROOM_LIMIT = (QUEUE_AW+2)'(DEPTH - 2);

	logic [15:0]         capacity_q;
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	logic [QUEUE_AW:0]   queue_count;
	logic [QUEUE_AW+1:0] committed;
	logic                accept;
	b32d_pkg::push_t     push;

	// capacity register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= b32d_pkg::CAPACITY_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.data;
		end
	end

	// input flow control: room for two results from the stage and two more
	assign committed     = (QUEUE_AW+2)'(queue_count) + (valid_s1 ? (QUEUE_AW+2)'(2) : '0);
	assign char_in.ready = committed <= ROOM_LIMIT;
	assign accept        = char_in.valid && char_in.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in.char_code;
			last_s1 <= char_in.end_of_string;
		end
	end

	b32d_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.last_s1  (last_s1),
		.capacity (capacity_q),
		.push     (push)
	);

	b32d_result_queue #(
		.AW (QUEUE_AW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.count      (queue_count),
		.result_out (result_out)
	);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the base32 decoder unit
// Streams characters into the decoder, runs each accepted request through a
// local decode of the same behavior, and checks every result field in order.
// Directed strings come first, then random strings under three stall mixes,
// with the output capacity rewritten between strings.
// ----------------------------------------------------------------------------
module tb_top;
	import b32d_pkg::*;

	localparam int QUIET_CYCLES   = 6;     // decode latency plus margin
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted request
	localparam int RANDOM_CHARS   = 500;   // per stall mix

	logic clk;
	logic arst_n;

	b32d_char_if   char_in();
	b32d_result_if result_out();
	b32d_cfg_if    cfg();

	base32_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	// mirrored decoder state
	logic [15:0] capacity;
	logic [11:0] bit_buf;
	logic [3:0]  bit_cnt;
	logic [15:0] byte_cnt;
	logic        skipping_rest;

	result_t decoded_results[$];
	int      sent_chars = 0;      // accepted character requests
	int      bad_results = 0;
	int      idle_cycles = 0;
	int      char_gap_pct = 0;
	int      result_stall_pct = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// decode model
	// ------------------------------------------------------------------------
	function automatic bit is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF ||
			ch == CH_DASH || ch == CH_DOT;
	endfunction

	// 0..31 for an alphabet character, -1 otherwise
	function automatic int char_value(input logic [7:0] ch);
		logic [7:0] c;
		c = ch;
		if (c == CH_ZERO) c = CH_UP_O;
		else if (c == CH_ONE) c = CH_UP_L;
		else if (c == CH_EIGHT) c = CH_UP_B;
		if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z))
			return int'(c & LETTER_MASK) - 1;
		if (c >= CH_TWO && c <= CH_SEVEN)
			return int'(c) - int'(DIGIT_BASE);
		return -1;
	endfunction

	function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data,
		input logic [15:0] count, input logic room);
		result_t r;
		r.kind = kind;
		r.data_byte = data;
		r.byte_count = count;
		r.has_room = room;
		r.end_of_run = 1'b0;
		return r;
	endfunction

	task automatic clear_string_state();
		bit_buf = '0;
		bit_cnt = '0;
		byte_cnt = '0;
		skipping_rest = 1'b0;
	endtask

	// queue up the results one accepted character causes
	task automatic decode_char(input logic [7:0] ch, input logic eos);
		result_t outs[2];
		int      n;
		int      v;
		bit      failed;
		n = 0;
		failed = 0;
		sent_chars++;
		if (skipping_rest) begin
			if (eos) clear_string_state();
			return;
		end

		if (ch == CH_NUL) begin
			outs[n] = make_result(KIND_DONE, 8'd0, byte_cnt, byte_cnt < capacity);
			n++;
			clear_string_state();
			skipping_rest = !eos;
		end else begin
			if (byte_cnt < capacity && !is_blank(ch)) begin
				v = char_value(ch);
				if (v < 0) begin
					outs[n] = make_result(KIND_ERROR, 8'd0, byte_cnt, 1'b0);
					n++;
					clear_string_state();
					skipping_rest = !eos;
					failed = 1;
				end else begin
					bit_buf = {bit_buf[6:0], v[4:0]};
					bit_cnt = bit_cnt + 4'd5;
					if (bit_cnt >= 4'd8) begin
						bit_cnt = bit_cnt - 4'd8;
						byte_cnt = byte_cnt + 16'd1;
						outs[n] = make_result(KIND_BYTE, 8'(bit_buf >> bit_cnt), byte_cnt, 1'b0);
						n++;
						bit_buf = bit_buf & ((12'd1 << bit_cnt) - 12'd1);
					end
				end
			end
			if (eos && !failed) begin
				outs[n] = make_result(KIND_DONE, 8'd0, byte_cnt, byte_cnt < capacity);
				n++;
				clear_string_state();
			end
		end

		if (n > 0) outs[n - 1].end_of_run = 1'b1;
		for (int i = 0; i < n; i++) decoded_results.push_back(outs[i]);
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls, in-order check
	// ------------------------------------------------------------------------
	initial begin
		result_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_out.ready <= ($urandom_range(99) >= result_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			got.kind = result_out.kind;
			got.data_byte = result_out.data_byte;
			got.byte_count = result_out.byte_count;
			got.has_room = result_out.has_room;
			got.end_of_run = result_out.end_of_run;
			if (decoded_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: unexpected result kind=%0d byte=%02h count=%0d room=%0b last=%0b",
						$realtime, got.kind, got.data_byte, got.byte_count, got.has_room,
						got.end_of_run);
			end else begin
				want = decoded_results.pop_front();
				if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
					got.byte_count !== want.byte_count || got.has_room !== want.has_room ||
					got.end_of_run !== want.end_of_run) begin
					bad_results++;
					if (bad_results <= 10)
						$display({"%0t: result mismatch: expected kind=%0d byte=%02h count=%0d",
							" room=%0b last=%0b, got kind=%0d byte=%02h count=%0d room=%0b last=%0b"},
							$realtime, want.kind, want.data_byte, want.byte_count, want.has_room,
							want.end_of_run, got.kind, got.data_byte, got.byte_count, got.has_room,
							got.end_of_run);
				end
			end
		end
	end

	// watchdog: any accepted request on any channel restarts the count
	always @(posedge clk) begin
		if ((char_in.valid && char_in.ready) || (result_out.valid && result_out.ready) ||
			(cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	// one character request; valid stays high until the next call or a release
	task automatic send_char(input logic [7:0] ch, input logic eos);
		@(negedge clk);
		while ($urandom_range(99) < char_gap_pct) begin
			char_in.valid <= 1'b0;
			@(negedge clk);
		end
		char_in.valid <= 1'b1;
		char_in.char_code <= ch;
		char_in.end_of_string <= eos;
		do @(posedge clk); while (!char_in.ready);
		decode_char(ch, eos);
	endtask

	// whole string, end_of_string on its last character
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// drop valid and wait until the decoder has drained
	task automatic settle();
		@(negedge clk);
		char_in.valid <= 1'b0;
		while (decoded_results.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		capacity = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char(input bit noisy);
		int r;
		r = $urandom_range(99);
		if (noisy && r < 12) return 8'($urandom_range(255));
		if (noisy && r < 15) return CH_NUL;
		if (r >= 85) begin
			case ($urandom_range(5))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_CR;
				3: return CH_LF;
				4: return CH_DASH;
				default: return CH_DOT;
			endcase
		end
		case ($urandom_range(4))
			0: return CH_LO_A + 8'($urandom_range(25));
			1: return CH_TWO + 8'($urandom_range(5));
			2: begin
				case ($urandom_range(2))
					0: return CH_ZERO;
					1: return CH_ONE;
					default: return CH_EIGHT;
				endcase
			end
			default: return CH_UP_A + 8'($urandom_range(25));
		endcase
	endfunction

	// mostly clean strings; some carry bad characters and early NULs
	task automatic send_random_string();
		int len;
		bit noisy;
		len = ($urandom_range(15) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 16);
		noisy = ($urandom_range(3) == 0);
		for (int i = 0; i < len; i++)
			send_char(pick_char(noisy), 1'b0);
		case ($urandom_range(9))
			0: send_char(CH_NUL, 1'b1);
			1: send_char(8'($urandom_range(255)), 1'b1);
			default: send_char(pick_char(noisy), 1'b1);
		endcase
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_alphabet_and_aliases();
		// both letter cases and digit ends; last char completes a byte
		send_text("a2Z7");
		// every skipped character, then the 0/1/8 aliases
		send_text(" \t\r\n-.018");
	endtask

	task automatic test_invalid_characters();
		// error mid-string: rest discarded, NUL included, end clears quietly
		send_char("A", 1'b0);
		send_char(8'hff, 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char("B", 1'b1);
		// error on the final character
		send_text("@");
	endtask

	task automatic test_nul_terminator();
		// NUL before the end: done now, tail discarded
		send_char("C", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char("D", 1'b1);
		// NUL as the final character of an empty string
		send_char(CH_NUL, 1'b1);
	endtask

	task automatic test_capacity_limit();
		// one byte allowed: later characters ignored unchecked, no room at done
		settle();
		write_capacity(16'd1);
		send_text("AA@A");
		// zero capacity ignores everything
		settle();
		write_capacity(16'd0);
		send_text("!");
		settle();
		write_capacity(CAPACITY_RESET);
	endtask

	task automatic test_random_strings(input int n_chars);
		int          start;
		logic [15:0] cap_value;
		start = sent_chars;
		while (sent_chars - start < n_chars) begin
			// new capacity only between strings, once everything has drained
			if ($urandom_range(5) == 0) begin
				case ($urandom_range(9))
					0: cap_value = 16'd0;
					1: cap_value = 16'($urandom_range(65535));
					2, 3: cap_value = 16'($urandom_range(1, 3));
					4, 5, 6: cap_value = 16'($urandom_range(4, 12));
					default: cap_value = CAPACITY_RESET;
				endcase
				settle();
				write_capacity(cap_value);
			end
			send_random_string();
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		char_in.valid = 1'b0;
		char_in.char_code = CH_NUL;
		char_in.end_of_string = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		capacity = CAPACITY_RESET;
		clear_string_state();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		char_gap_pct = 14;
		result_stall_pct = 83;
		test_alphabet_and_aliases();
		test_invalid_characters();
		test_nul_terminator();
		test_capacity_limit();
		test_random_strings(RANDOM_CHARS);

		char_gap_pct = 83;
		result_stall_pct = 14;
		test_random_strings(RANDOM_CHARS);

		char_gap_pct = 0;
		result_stall_pct = 0;
		test_random_strings(RANDOM_CHARS);

		settle();
		if (bad_results == 0 && decoded_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- base32_decoder_unit.f -----
rtl/core/b32d_pkg.sv
rtl/core/b32d_if.sv
rtl/core/b32d_decode.sv
rtl/core/b32d_result_queue.sv
rtl/core/base32_decoder_unit.sv
dv/tb_top.sv
